// ===== rtl/gaussian_polar_generator_unit_assert.svh =====
// assertion macros used by the gaussian generator unit
`ifndef GAUSSIAN_POLAR_GENERATOR_UNIT_ASSERT_SVH
`define GAUSSIAN_POLAR_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define GPG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpg assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define GPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpg assertion failed");

`endif

// ===== rtl/gpg_pkg.sv =====
// shared types and fixed-point constants of the gaussian generator
package gpg_pkg;

    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int OUT_BITS       = 21;

    localparam int MANT_BITS      = 31;   // mantissa in q1.30
    localparam int MANT_FRAC      = 30;
    localparam int LOG_FRAC       = 24;
    localparam int NL_BITS        = 30;   // -log2(w) in q.24, p below 64
    localparam int LN2_BITS       = 32;
    localparam int LN2_SHIFT      = 31;
    localparam int ROOT_PRESHIFT  = 8;
    localparam int ROOT_IN_BITS   = 40;
    localparam int ROOT_BITS      = 20;
    localparam int YMAG_BITS      = 24;
    localparam int SCALE_STAGES   = 4;

    localparam logic [LN2_BITS-1:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [CFG_BITS-1:0] STD_DEV_RESET = 16'd256;
    localparam int OUT_MAX = 1048575;
    localparam int OUT_MIN = -1048576;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MEAN_OFFSET = 1'b0,
        REG_STD_DEV     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CFG_BITS-1:0] mean_offset;
        logic [CFG_BITS-1:0]        std_dev;
    } cfg_t;

endpackage

// ===== rtl/gpg_if.sv =====
// valid/ready channels for uniform pairs in and gaussian words out
interface gpg_uniform_if #(parameter int WIDTH = 16);
    logic              valid;
    logic              ready;
    logic signed [WIDTH-1:0] uniform_a;
    logic signed [WIDTH-1:0] uniform_b;

    modport source (output valid, output uniform_a, output uniform_b, input ready);
    modport sink (input valid, input uniform_a, input uniform_b, output ready);
endinterface

interface gpg_normal_if;
    logic valid;
    logic ready;
    logic signed [gpg_pkg::OUT_BITS-1:0] normal_value;
    logic last_of_pair;

    modport source (output valid, output normal_value, output last_of_pair, input ready);
    modport sink (input valid, input normal_value, input last_of_pair, output ready);
endinterface

// ===== rtl/gaussian_polar_generator_unit.sv =====
// the pipeline takes one pair per cycle while no output pair is owed; each pair
// inside the circle yields two words over the single output port, and the
// pipeline holds until both are taken; rejected pairs never hold it; it has
// 24 log, 31 divide and 20 root stages
// reset clears all valid bits, the output pair's too, and sets mean 0, stddev 1.0
// there is no clearing pass; the block is ready in the first cycle after reset
module gaussian_polar_generator_unit #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gpg_pkg::CFG_BITS-1:0]        cfg_data,
    gpg_uniform_if.sink                         uniforms,
    gpg_normal_if.source                        normals
);

`include "gaussian_polar_generator_unit_assert.svh"

    localparam int UB      = UNIFORM_BITS;
    localparam int FB      = UB - 1;
    localparam int W2      = 2 * FB;
    localparam int SQ_BITS = W2 + 1;
    localparam int SUMW    = W2 + 2;
    localparam int E_BITS  = $clog2(W2);
    localparam int P_BITS  = $clog2(W2 + 1);
    localparam int SH_BITS = $clog2(UB);
    localparam int MANT    = gpg_pkg::MANT_BITS;
    localparam int LOGN    = gpg_pkg::LOG_FRAC;
    localparam int DIV_N   = gpg_pkg::MANT_BITS;
    localparam int ROOT_N  = gpg_pkg::ROOT_BITS;
    localparam int RIN     = gpg_pkg::ROOT_IN_BITS;
    localparam int NLB     = gpg_pkg::NL_BITS;
    localparam int RPROD   = NLB + gpg_pkg::LN2_BITS;

    // valid chain positions
    localparam int IDX_SQ    = 0;
    localparam int IDX_W     = 1;
    localparam int IDX_LOG   = IDX_W + 3;     // after encode and normalize
    localparam int IDX_NL    = IDX_LOG + LOGN;
    localparam int IDX_R     = IDX_NL + 1;
    localparam int IDX_DIV   = IDX_R + 1;
    localparam int IDX_ROOT  = IDX_DIV + DIV_N;
    localparam int IDX_SCALE = IDX_ROOT + ROOT_N;
    localparam int NV        = IDX_SCALE + gpg_pkg::SCALE_STAGES;

    typedef struct packed {
        logic [FB-1:0] amag;
        logic [FB-1:0] bmag;
        logic          aneg;
        logic          bneg;
    } xs_t;

    typedef struct packed {
        xs_t              xs;
        logic [P_BITS-1:0] p;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [MANT-1:0]  mant;
    } lside_t;

    logic en;
    logic [NV-1:0] vld_reg, vld_next;

    gpg_pkg::cfg_t cfg_reg, cfg_next;
    logic pair_valid_reg, pair_valid_next;
    logic phase_reg, phase_next;
    logic signed [gpg_pkg::OUT_BITS-1:0] val_a_reg, val_b_reg, value_a, value_b;

    // magnitude and square
    logic [UB-1:0]       raw_a, raw_b, mag_a, mag_b;
    logic [2*UB-1:0]     sq_a_full, sq_b_full;
    logic [UB-1:0]       mag_a_reg, mag_b_reg;
    logic                neg_a_reg, neg_b_reg;
    logic [SQ_BITS-1:0]  sq_a_reg, sq_b_reg;

    // sum, encode, normalize
    logic [SUMW-1:0]     w_sum;
    logic                w_ok;
    logic [W2-1:0]       w_reg, w3_reg;
    xs_t                 xs2_reg, xs3_reg, xs2_next;
    logic [E_BITS-1:0]   e_reg, e_next;
    logic [W2-1:0]       norm;
    logic [W2+MANT-1:0]  norm_ext;
    logic [MANT-1:0]     mant_reg, mant_next;
    side_t               side4_reg, side4_next;

    // log2 by repeated squaring
    logic [MANT-1:0]     lm_reg [LOGN], lm_next [LOGN], lm_in [LOGN];
    logic [LOGN-1:0]     lf_reg [LOGN], lf_next [LOGN], lf_in [LOGN];
    lside_t              ls_reg [LOGN], ls_in [LOGN];

    // -2 ln w
    logic [NLB-1:0]      nl_reg, nl_next;
    lside_t              nlside_reg, rside_reg;
    logic [RPROD-1:0]    r_prod;
    logic [MANT-1:0]     r_reg, r_next;

    // restoring divide
    logic [MANT:0]       dr_in [DIV_N];
    logic [MANT-1:0]     dr_reg [DIV_N], dr_next [DIV_N];
    logic [MANT-1:0]     dq_reg [DIV_N], dq_next [DIV_N], dq_in [DIV_N];
    lside_t              ds_reg [DIV_N], ds_in [DIV_N];

    // square root
    logic [RIN-1:0]      rn_reg [ROOT_N], rn_next [ROOT_N], rn_in [ROOT_N];
    logic [RIN-1:0]      rr_reg [ROOT_N], rr_next [ROOT_N], rr_in [ROOT_N];
    side_t               rs_reg [ROOT_N], rs_in [ROOT_N];
    logic [SH_BITS-1:0]  root_shift;

    // pipeline advances unless the output pair is still owed
    assign en = !pair_valid_reg || (phase_reg && normals.ready);
    assign uniforms.ready = en;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (gpg_pkg::cfg_reg_t'(cfg_index))
                gpg_pkg::REG_MEAN_OFFSET: cfg_next.mean_offset = signed'(cfg_data);
                gpg_pkg::REG_STD_DEV:     cfg_next.std_dev = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // front stages
    always_comb
    begin
        raw_a     = uniforms.uniform_a;
        raw_b     = uniforms.uniform_b;
        mag_a     = raw_a[UB-1] ? (~raw_a + 1'b1) : raw_a;
        mag_b     = raw_b[UB-1] ? (~raw_b + 1'b1) : raw_b;
        sq_a_full = (2*UB)'(mag_a) * (2*UB)'(mag_a);
        sq_b_full = (2*UB)'(mag_b) * (2*UB)'(mag_b);

        w_sum = SUMW'(sq_a_reg) + SUMW'(sq_b_reg);
        // reject the zero pair and anything on or outside the unit circle
        w_ok  = (w_sum != '0) && (w_sum[SUMW-1:W2] == '0);
        xs2_next.amag = mag_a_reg[FB-1:0];
        xs2_next.bmag = mag_b_reg[FB-1:0];
        xs2_next.aneg = neg_a_reg;
        xs2_next.bneg = neg_b_reg;

        e_next = '0;
        for (int i = 0; i < W2; i++)
        begin
            if (w_reg[i])
            begin
                e_next = E_BITS'(i);
            end
        end

        norm      = w3_reg << (E_BITS'(W2 - 1) - e_reg);
        norm_ext  = {norm, {MANT{1'b0}}};
        mant_next = norm_ext[W2+MANT-1 -: MANT];
        side4_next.xs = xs3_reg;
        side4_next.p  = P_BITS'(W2) - P_BITS'(e_reg);
    end

    // log stage inputs
    always_comb
    begin
        lm_in[0] = mant_reg;
        lf_in[0] = '0;
        ls_in[0] = '{side: side4_reg, mant: mant_reg};
        for (int k = 1; k < LOGN; k++)
        begin
            lm_in[k] = lm_reg[k-1];
            lf_in[k] = lf_reg[k-1];
            ls_in[k] = ls_reg[k-1];
        end
    end

    always_comb
    begin
        logic [2*MANT-1:0]   sq;
        logic [MANT:0]       sqh;
        for (int k = 0; k < LOGN; k++)
        begin
            sq  = (2*MANT)'(lm_in[k]) * (2*MANT)'(lm_in[k]);
            sqh = sq[2*MANT-1:gpg_pkg::MANT_FRAC];
            // square reached 2.0: emit a one and halve
            lm_next[k] = sqh[MANT] ? sqh[MANT:1] : sqh[MANT-1:0];
            lf_next[k] = lf_in[k] | (sqh[MANT] ? (LOGN'(1) << (LOGN - 1 - k)) : {LOGN{1'b0}});
        end
    end

    always_comb
    begin
        nl_next = (NLB'(ls_reg[LOGN-1].side.p) << LOGN) - NLB'(lf_reg[LOGN-1]);
        r_prod  = RPROD'(nl_reg) * RPROD'(gpg_pkg::LN2_Q32);
        r_next  = r_prod[gpg_pkg::LN2_SHIFT+MANT-1:gpg_pkg::LN2_SHIFT];
    end

    // divide stage inputs: first step compares r itself, then remainder doubles
    always_comb
    begin
        dr_in[0] = {1'b0, r_reg};
        dq_in[0] = '0;
        ds_in[0] = rside_reg;
        for (int k = 1; k < DIV_N; k++)
        begin
            dr_in[k] = {dr_reg[k-1], 1'b0};
            dq_in[k] = dq_reg[k-1];
            ds_in[k] = ds_reg[k-1];
        end
    end

    always_comb
    begin
        logic          qb;
        logic [MANT:0] diff;
        for (int k = 0; k < DIV_N; k++)
        begin
            qb   = dr_in[k] >= {1'b0, ds_in[k].mant};
            diff = dr_in[k] - {1'b0, ds_in[k].mant};
            dr_next[k] = qb ? diff[MANT-1:0] : dr_in[k][MANT-1:0];
            dq_next[k] = dq_in[k] | (qb ? (MANT'(1) << (MANT - 1 - k)) : {MANT{1'b0}});
        end
    end

    // root stage inputs: odd exponent doubles t
    always_comb
    begin
        rn_in[0] = RIN'({dq_reg[DIV_N-1], {gpg_pkg::ROOT_PRESHIFT{1'b0}}})
                   << ds_reg[DIV_N-1].side.p[0];
        rr_in[0] = '0;
        rs_in[0] = ds_reg[DIV_N-1].side;
        for (int j = 1; j < ROOT_N; j++)
        begin
            rn_in[j] = rn_reg[j-1];
            rr_in[j] = rr_reg[j-1];
            rs_in[j] = rs_reg[j-1];
        end
    end

    always_comb
    begin
        logic [RIN-1:0] bitv;
        logic [RIN-1:0] trial;
        for (int j = 0; j < ROOT_N; j++)
        begin
            bitv  = RIN'(1) << (RIN - 2 - 2 * j);
            trial = rr_in[j] + bitv;
            if (rn_in[j] >= trial)
            begin
                rn_next[j] = rn_in[j] - trial;
                rr_next[j] = (rr_in[j] >> 1) + bitv;
            end
            else
            begin
                rn_next[j] = rn_in[j];
                rr_next[j] = rr_in[j] >> 1;
            end
        end
    end

    // floor(p/2) is the same before and after the odd adjust
    assign root_shift = SH_BITS'(FB - int'(rs_reg[ROOT_N-1].p >> 1));

    gpg_scale #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_scale_a (
        .clk   (clk),
        .en    (en),
        .xmag  (rs_reg[ROOT_N-1].xs.amag),
        .xneg  (rs_reg[ROOT_N-1].xs.aneg),
        .root  (rr_reg[ROOT_N-1][ROOT_N-1:0]),
        .shift (root_shift),
        .cfg   (cfg_reg),
        .value (value_a)
    );

    gpg_scale #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_scale_b (
        .clk   (clk),
        .en    (en),
        .xmag  (rs_reg[ROOT_N-1].xs.bmag),
        .xneg  (rs_reg[ROOT_N-1].xs.bneg),
        .root  (rr_reg[ROOT_N-1][ROOT_N-1:0]),
        .shift (root_shift),
        .cfg   (cfg_reg),
        .value (value_b)
    );

    // valid bits; the scale lanes keep no valid of their own
    always_comb
    begin
        vld_next = {vld_reg[NV-2:0], uniforms.valid};
        vld_next[IDX_W] = vld_reg[IDX_SQ] & w_ok;

        pair_valid_next = pair_valid_reg;
        phase_next      = phase_reg;
        if (en)
        begin
            pair_valid_next = vld_reg[NV-1];
            phase_next      = 1'b0;
        end
        else if (!phase_reg && normals.ready)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            pair_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            cfg_reg        <= '{mean_offset: '0, std_dev: gpg_pkg::STD_DEV_RESET};
        end
        else
        begin
            if (en)
            begin
                vld_reg <= vld_next;
            end
            pair_valid_reg <= pair_valid_next;
            phase_reg      <= phase_next;
            cfg_reg        <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg  <= mag_a;
            mag_b_reg  <= mag_b;
            neg_a_reg  <= raw_a[UB-1];
            neg_b_reg  <= raw_b[UB-1];
            sq_a_reg   <= sq_a_full[SQ_BITS-1:0];
            sq_b_reg   <= sq_b_full[SQ_BITS-1:0];
            w_reg      <= w_sum[W2-1:0];
            xs2_reg    <= xs2_next;
            e_reg      <= e_next;
            w3_reg     <= w_reg;
            xs3_reg    <= xs2_reg;
            mant_reg   <= mant_next;
            side4_reg  <= side4_next;
            for (int k = 0; k < LOGN; k++)
            begin
                lm_reg[k] <= lm_next[k];
                lf_reg[k] <= lf_next[k];
                ls_reg[k] <= ls_in[k];
            end
            nl_reg     <= nl_next;
            nlside_reg <= ls_reg[LOGN-1];
            r_reg      <= r_next;
            rside_reg  <= nlside_reg;
            for (int k = 0; k < DIV_N; k++)
            begin
                dr_reg[k] <= dr_next[k];
                dq_reg[k] <= dq_next[k];
                ds_reg[k] <= ds_in[k];
            end
            for (int j = 0; j < ROOT_N; j++)
            begin
                rn_reg[j] <= rn_next[j];
                rr_reg[j] <= rr_next[j];
                rs_reg[j] <= rs_in[j];
            end
            val_a_reg  <= value_a;
            val_b_reg  <= value_b;
        end
    end

    assign normals.valid        = pair_valid_reg;
    assign normals.normal_value = phase_reg ? val_b_reg : val_a_reg;
    assign normals.last_of_pair = phase_reg;

    // first word of a pair taken means the second is up next
    `GPG_ASSERT_NEXT(a_second_follows,
        normals.valid && normals.ready && !normals.last_of_pair,
        normals.valid && normals.last_of_pair)
    `GPG_ASSERT_IMPL(a_ready_when_empty, !pair_valid_reg, uniforms.ready)
    `GPG_ASSERT_IMPL(a_w_nonzero, vld_reg[IDX_W], w_reg != '0)
    `GPG_ASSERT_IMPL(a_div_remainder,
        vld_reg[IDX_ROOT-1], dr_reg[DIV_N-1] < ds_reg[DIV_N-1].mant)

endmodule

// ===== rtl/gpg_scale.sv =====
// one output lane: x times root, exponent shift, stddev scaling, mean add
module gpg_scale #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [UNIFORM_BITS-2:0]             xmag,
    input  logic                                xneg,
    input  logic [gpg_pkg::ROOT_BITS-1:0]       root,
    input  logic [$clog2(UNIFORM_BITS)-1:0]     shift,
    input  gpg_pkg::cfg_t                       cfg,
    output logic signed [gpg_pkg::OUT_BITS-1:0] value
);

    localparam int FB        = UNIFORM_BITS - 1;
    localparam int SH_BITS   = $clog2(UNIFORM_BITS);
    localparam int PROD_BITS = FB + gpg_pkg::ROOT_BITS;
    localparam int YB        = gpg_pkg::YMAG_BITS;
    localparam int DPROD     = YB + gpg_pkg::CFG_BITS;
    localparam int SUMB      = YB + 2;

    logic [PROD_BITS-1:0] prod_reg, prod_next;
    logic [SH_BITS-1:0]   shift_reg;
    logic                 neg_a_reg, neg_b_reg, neg_c_reg;
    logic [YB-1:0]        ymag_reg, ymag_next;
    logic [YB-1:0]        d_reg, d_next;
    logic signed [gpg_pkg::OUT_BITS-1:0] value_reg, value_next;

    logic [PROD_BITS-1:0] shifted;
    logic [DPROD-1:0]     dprod;
    logic signed [SUMB-1:0] mean_ext, d_ext, sum;

    always_comb
    begin
        prod_next = PROD_BITS'(xmag) * PROD_BITS'(root);
        shifted   = prod_reg >> shift_reg;
        // clamp, never reached by a pair inside the circle
        ymag_next = (|shifted[PROD_BITS-1:YB]) ? {YB{1'b1}} : shifted[YB-1:0];
        dprod     = DPROD'(ymag_reg) * DPROD'(cfg.std_dev)
                    + (DPROD'(1) << (gpg_pkg::CFG_BITS - 1));
        d_next    = dprod[DPROD-1:gpg_pkg::CFG_BITS];
        mean_ext  = SUMB'(cfg.mean_offset);
        d_ext     = signed'({2'b00, d_reg});
        // sign applied after rounding, so rounding is symmetric
        sum       = neg_c_reg ? (mean_ext - d_ext) : (mean_ext + d_ext);
        if (sum > SUMB'(gpg_pkg::OUT_MAX))
        begin
            value_next = gpg_pkg::OUT_BITS'(gpg_pkg::OUT_MAX);
        end
        else if (sum < SUMB'(gpg_pkg::OUT_MIN))
        begin
            value_next = gpg_pkg::OUT_BITS'(gpg_pkg::OUT_MIN);
        end
        else
        begin
            value_next = sum[gpg_pkg::OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            shift_reg <= shift;
            neg_a_reg <= xneg;
            ymag_reg  <= ymag_next;
            neg_b_reg <= neg_a_reg;
            d_reg     <= d_next;
            neg_c_reg <= neg_b_reg;
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== tb/sv/gaussian_polar_generator_unit_tb.sv =====
// testbench for the polar gaussian generator: pair stimulus, bit-exact prediction, word checks
module gaussian_polar_generator_unit_tb;

    localparam int UBITS       = 16;
    localparam int FBITS       = UBITS - 1;
    localparam int SETTLE      = 120;      // more than the pipeline depth
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [gpg_pkg::OUT_BITS-1:0] value;
        logic                         last;
    } normal_word_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [gpg_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [gpg_pkg::CFG_BITS-1:0] cfg_data;

    gpg_uniform_if #(.WIDTH(UBITS)) uniforms();
    gpg_normal_if normals();

    gaussian_polar_generator_unit #(.UNIFORM_BITS(UBITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .uniforms  (uniforms.sink),
        .normals   (normals.source)
    );

    // copy of the block's registers
    logic signed [gpg_pkg::CFG_BITS-1:0] mean_reg;
    logic [gpg_pkg::CFG_BITS-1:0] sdev_reg;

    normal_word_t expected_words[$];
    int mismatch_count;
    int words_seen;
    int pairs_sent;
    int pairs_rejected;
    int cycle_count;

    // receiver controls
    bit rx_idle_enable;
    int rx_hold_request;

    // sender control
    bit tx_idle_enable;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > n)
            bitpos >>= 2;
        while (bitpos != 0)
        begin
            if (n >= root + bitpos)
            begin
                n -= root + bitpos;
                root = (root >> 1) + bitpos;
            end
            else
                root >>= 1;
            bitpos >>= 2;
        end
        return root;
    endfunction

    function automatic logic [gpg_pkg::OUT_BITS-1:0] scale_variate(longint unsigned xmag,
                                                                   bit neg,
                                                                   longint unsigned root,
                                                                   int shift);
        longint unsigned ymag;
        longint unsigned dev;
        longint sum;
        ymag = (xmag * root) >> shift;
        if (ymag > 64'hFF_FFFF)
            ymag = 64'hFF_FFFF;
        dev = (ymag * longint'(sdev_reg) + (64'd1 << 15)) >> 16;
        sum = neg ? longint'(mean_reg) - longint'(dev) : longint'(mean_reg) + longint'(dev);
        if (sum > gpg_pkg::OUT_MAX)
            sum = gpg_pkg::OUT_MAX;
        if (sum < gpg_pkg::OUT_MIN)
            sum = gpg_pkg::OUT_MIN;
        return sum[gpg_pkg::OUT_BITS-1:0];
    endfunction

    // works out the words of one pair and queues them; rejected pairs give none
    task automatic predict_gaussian_pair(logic [UBITS-1:0] a, logic [UBITS-1:0] b);
        longint unsigned amag, bmag, w, mant, sq, frac, nl, r, t, root;
        bit aneg, bneg;
        int e, p, shift;
        normal_word_t word;
        aneg = a[UBITS-1];
        bneg = b[UBITS-1];
        amag = aneg ? (64'd1 << UBITS) - a : a;
        bmag = bneg ? (64'd1 << UBITS) - b : b;
        w = amag * amag + bmag * bmag;
        if (w == 0 || w >= (64'd1 << (2 * FBITS)))
        begin
            pairs_rejected++;
            return;
        end
        e = 0;
        while ((w >> (e + 1)) != 0)
            e++;
        p = 2 * FBITS - e;
        mant = (e > 30) ? (w >> (e - 30)) : (w << (30 - e));
        sq = mant;
        frac = 0;
        for (int i = 0; i < gpg_pkg::LOG_FRAC; i++)
        begin
            sq = (sq * sq) >> 30;
            if (sq >= (64'd1 << 31))
            begin
                sq >>= 1;
                frac |= 64'd1 << (gpg_pkg::LOG_FRAC - 1 - i);
            end
        end
        nl = (longint'(p) << gpg_pkg::LOG_FRAC) - frac;
        r = (nl * 64'hB172_17F8) >> 31;
        t = (r << 30) / mant;
        if (p % 2 == 1)
        begin
            t <<= 1;
            p -= 1;
        end
        root = int_sqrt(t << 8);
        shift = FBITS - p / 2;
        word.value = scale_variate(amag, aneg, root, shift);
        word.last = 1'b0;
        expected_words = {expected_words, word};
        word.value = scale_variate(bmag, bneg, root, shift);
        word.last = 1'b1;
        expected_words = {expected_words, word};
    endtask

    // receiver: random stalls, long hold-offs on request, checks each word
    always @(posedge clk or negedge rst_n)
    begin
        normal_word_t want;
        if (!rst_n)
            normals.ready <= 1'b0;
        else
        begin
            if (normals.valid && normals.ready)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word value=%0d last=%0b",
                                 normals.normal_value, normals.last_of_pair);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (normals.normal_value !== want.value
                        || normals.last_of_pair !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("word mismatch: expected %0d/%0b got %0d/%0b",
                                     $signed(want.value), want.last,
                                     normals.normal_value, normals.last_of_pair);
                    end
                end
            end
            if (rx_hold_request > 0)
            begin
                normals.ready <= 1'b0;
                rx_hold_request <= rx_hold_request - 1;
            end
            else if (rx_idle_enable)
                normals.ready <= ($urandom_range(0, 99) >= 34);
            else
                normals.ready <= 1'b1;
        end
    end

    // offers one pair and waits until it is taken
    task automatic send_pair(logic [UBITS-1:0] a, logic [UBITS-1:0] b);
        // idle cycles drawn one at a time
        while (tx_idle_enable && $urandom_range(0, 99) < 34)
        begin
            uniforms.valid <= 1'b0;
            @(posedge clk);
        end
        uniforms.valid <= 1'b1;
        uniforms.uniform_a <= a;
        uniforms.uniform_b <= b;
        @(posedge clk);
        while (!uniforms.ready)
            @(posedge clk);
        pairs_sent++;
        predict_gaussian_pair(a, b);
    endtask

    task automatic stop_sending();
        uniforms.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(gpg_pkg::cfg_reg_t index,
                                  logic [gpg_pkg::CFG_BITS-1:0] value);
        stop_sending();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == gpg_pkg::REG_MEAN_OFFSET)
            mean_reg = value;
        else
            sdev_reg = value;
    endtask

    function automatic logic [UBITS-1:0] random_uniform();
        // a share of small draws pushes w toward the deep end of the log range
        if ($urandom_range(0, 99) < 20)
            return UBITS'($signed($urandom_range(0, 511)) - 256);
        return UBITS'($urandom());
    endfunction

    task automatic test_directed_extremes();
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd32768, 16'sd0);
        send_pair(16'sd0, -16'sd32768);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(16'sd32767, 16'sd0);
        send_pair(16'sd0, 16'sd32767);
        send_pair(16'sd1, 16'sd0);
        send_pair(16'sd0, -16'sd1);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sd23170, 16'sd23170);
        send_pair(16'sd23171, 16'sd23171);
        send_pair(-16'sd23170, 16'sd23170);
        send_pair(16'sd16384, 16'sd0);
        send_pair(16'sd100, -16'sd200);
        send_pair(16'sd32767, 16'sd1);
        send_pair(-16'sd3, 16'sd2);
    endtask

    task automatic test_config_sweep();
        logic [gpg_pkg::CFG_BITS-1:0] means[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFF00};
        logic [gpg_pkg::CFG_BITS-1:0] sdevs[4] = '{16'hFFFF, 16'h0000, 16'h0001, 16'h1234};
        for (int k = 0; k < 4; k++)
        begin
            write_register(gpg_pkg::REG_MEAN_OFFSET, means[k]);
            write_register(gpg_pkg::REG_STD_DEV, sdevs[k]);
            test_directed_extremes();
            for (int i = 0; i < 40; i++)
                send_pair(random_uniform(), random_uniform());
        end
    endtask

    task automatic test_random_pairs(int count);
        write_register(gpg_pkg::REG_MEAN_OFFSET, gpg_pkg::CFG_BITS'($urandom()));
        write_register(gpg_pkg::REG_STD_DEV, gpg_pkg::CFG_BITS'($urandom_range(0, 2048)));
        for (int i = 0; i < count; i++)
        begin
            // a long run with no idling on either side
            if (i == count / 2)
            begin
                tx_idle_enable = 1'b0;
                rx_idle_enable = 1'b0;
            end
            if (i == count / 2 + 150)
            begin
                tx_idle_enable = 1'b1;
                rx_idle_enable = 1'b1;
            end
            send_pair(random_uniform(), random_uniform());
        end
    endtask

    task automatic test_backpressure();
        tx_idle_enable = 1'b0;
        rx_hold_request = 400;
        for (int i = 0; i < 150; i++)
            send_pair(random_uniform(), random_uniform());
        tx_idle_enable = 1'b1;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 30; i++)
            send_pair(random_uniform(), random_uniform());
        stop_sending();
        wait_drained();
        for (int i = 0; i < 30; i++)
            send_pair(random_uniform(), random_uniform());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = gpg_pkg::REG_MEAN_OFFSET;
        cfg_data = '0;
        uniforms.valid = 1'b0;
        uniforms.uniform_a = '0;
        uniforms.uniform_b = '0;
        normals.ready = 1'b0;
        mean_reg = '0;
        sdev_reg = gpg_pkg::STD_DEV_RESET;
        mismatch_count = 0;
        words_seen = 0;
        pairs_sent = 0;
        pairs_rejected = 0;
        cycle_count = 0;
        rx_idle_enable = 1'b1;
        rx_hold_request = 0;
        tx_idle_enable = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_config_sweep();
        test_backpressure();
        test_drain_pause();
        test_random_pairs(550);

        stop_sending();
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d uniform pairs (%0d rejected), checked %0d gaussian words",
                 pairs_sent, pairs_rejected, words_seen);
        $display("covered register extremes, stalls, long hold-off and drain pause");
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
